@@ rtl/gsag_pkg.sv @@
// Package for the gather source address generator: widths, codes, register map.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsag_pkg;
   localparam int TableDepthDefault = 1024;
   localparam int PosWidth  = 31;
   localparam int IdxWidth  = 64;
   localparam int SrcWidth  = 63;
   localparam int IbsWidth  = 40;
   localparam int QuoWidth  = 31;

   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_RESOLVE = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SLOT  = 2'd2;

   localparam logic [2:0] REG_IBS    = 3'd0;
   localparam logic [2:0] REG_AXIS   = 3'd1;
   localparam logic [2:0] REG_OUTER  = 3'd2;
   localparam logic [2:0] REG_INNER  = 3'd3;
   localparam logic [2:0] REG_NARROW = 3'd4;

   // one restoring-division stage carried down the pipeline
   typedef struct packed {
      logic                valid;
      logic [PosWidth-1:0] rem;
      logic [QuoWidth-1:0] quo;
   } div_stage_type;
endpackage
`default_nettype wire

@@ rtl/gsag_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, 31-bit unsigned.
// Depends on gsag_pkg. One transfer per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gsag_div
   import gsag_pkg::*;
#(
   parameter int SideWidth = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [PosWidth-1:0]  in_num,
   input  wire logic [PosWidth-1:0]  in_den,
   input  wire logic [SideWidth-1:0] in_side,
   output logic                      out_valid,
   output logic [QuoWidth-1:0]       out_quo,
   output logic [PosWidth-1:0]       out_rem,
   output logic [SideWidth-1:0]      out_side
);
   logic [PosWidth-1:0]  den_ff  [PosWidth];
   logic [SideWidth-1:0] side_ff [PosWidth];
   div_stage_type        stg_ff  [PosWidth];
   logic [PosWidth-1:0]  num_ff  [PosWidth];

   always_ff @(posedge clock) begin
      for (int s = 0; s < PosWidth; s++) begin
         logic [PosWidth-1:0] r_prev, n_prev, d;
         logic [QuoWidth-1:0] q_prev;
         logic [PosWidth:0]   trial;
         if (s == 0) begin
            r_prev = '0;
            n_prev = in_num;
            q_prev = '0;
            d      = (in_den == '0) ? PosWidth'(1) : in_den;
         end else begin
            r_prev = stg_ff[s-1].rem;
            n_prev = num_ff[s-1];
            q_prev = stg_ff[s-1].quo;
            d      = den_ff[s-1];
         end
         trial = {r_prev, n_prev[PosWidth-1]};
         if (trial >= {1'b0, d}) begin
            stg_ff[s].rem <= PosWidth'(trial - {1'b0, d});
            stg_ff[s].quo <= {q_prev[QuoWidth-2:0], 1'b1};
         end else begin
            stg_ff[s].rem <= trial[PosWidth-1:0];
            stg_ff[s].quo <= {q_prev[QuoWidth-2:0], 1'b0};
         end
         num_ff[s]  <= {n_prev[PosWidth-2:0], 1'b0};
         den_ff[s]  <= d;
         side_ff[s] <= (s == 0) ? in_side : side_ff[s-1];
         if (reset) stg_ff[s].valid <= 1'b0;
         else stg_ff[s].valid <= (s == 0) ? in_valid : stg_ff[s-1].valid;
      end
   end

   assign out_valid = stg_ff[PosWidth-1].valid;
   assign out_quo   = stg_ff[PosWidth-1].quo;
   assign out_rem   = stg_ff[PosWidth-1].rem;
   assign out_side  = side_ff[PosWidth-1];
endmodule
`default_nettype wire

@@ rtl/gather_source_address_generator.sv @@
// Top level of the gather source address generator: CSRs, index table memory,
// two divider pipelines, bound check and address sum. Depends on gsag_pkg, gsag_div.
`timescale 1ns / 1ps
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------
//  request  | start busy req_*               | transfer when start & !busy
//  response | rsp_valid rsp_*                | one-cycle strobe, no stall
//  csr      | csr_psel ... csr_pready        | APB, pready tied high
//
//  busy is always low: one request transfer per cycle. A resolve passes
//  through two 31-stage divider pipelines, then the registered stages for
//  table read, index fix-up, products and final sum.
//  Table writes ride the same pipelines and reach the memory in transfer
//  order, so each resolve sees exactly the writes that came before it.
//  Reset is synchronous; the table is not cleared. The receiver cannot stall.
`default_nettype none
module gather_source_address_generator
   import gsag_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_opcode,
   input  wire logic [PosWidth-1:0] req_position,
   input  wire logic signed [IdxWidth-1:0] req_index_value,
   output logic                     rsp_valid,
   output logic [PosWidth-1:0]      rsp_out_position,
   output logic [SrcWidth-1:0]      rsp_source_index,
   output logic [1:0]               rsp_status,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [5:0]          csr_paddr,
   input  wire logic [63:0]         csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // ---------------- configuration registers (8-byte stride)
   logic [IbsWidth-1:0] ibs_ff;
   logic [30:0]         axis_ff, outer_ff, inner_ff;
   logic                narrow_ff;
   logic [2:0]          csr_idx;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign busy       = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         ibs_ff    <= '0;
         axis_ff   <= 31'd1;
         outer_ff  <= 31'd1;
         inner_ff  <= 31'd1;
         narrow_ff <= 1'b1;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_IBS:    ibs_ff    <= csr_pwdata[IbsWidth-1:0];
            REG_AXIS:   axis_ff   <= csr_pwdata[30:0];
            REG_OUTER:  outer_ff  <= csr_pwdata[30:0];
            REG_INNER:  inner_ff  <= csr_pwdata[30:0];
            REG_NARROW: narrow_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_IBS:    csr_prdata = {24'd0, ibs_ff};
         REG_AXIS:   csr_prdata = {33'd0, axis_ff};
         REG_OUTER:  csr_prdata = {33'd0, outer_ff};
         REG_INNER:  csr_prdata = {33'd0, inner_ff};
         REG_NARROW: csr_prdata = {63'd0, narrow_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- index table memory
   logic [IdxWidth-1:0] table_mem [TABLE_DEPTH];
   logic                acc;
   assign acc = start & ~busy;

   // ---------------- first split: block, remainder
   // every transfer enters; opcode, value and position ride along
   localparam int Side1 = 1 + IdxWidth + PosWidth;
   logic                d1_v;
   logic [QuoWidth-1:0] d1_q;
   logic [PosWidth-1:0] d1_r;
   logic [Side1-1:0]    d1_side;

   gsag_div #(.SideWidth(Side1)) u_div_outer (
      .clock, .reset,
      .in_valid (acc),
      .in_num   (req_position),
      .in_den   (outer_ff),
      .in_side  ({req_opcode, req_index_value, req_position}),
      .out_valid(d1_v), .out_quo(d1_q), .out_rem(d1_r), .out_side(d1_side)
   );

   // ---------------- second split: slot, offset (block rides along)
   localparam int Side2 = Side1 + QuoWidth;
   logic                d2_v;
   logic [QuoWidth-1:0] d2_q;
   logic [PosWidth-1:0] d2_r;
   logic [Side2-1:0]    d2_side;

   gsag_div #(.SideWidth(Side2)) u_div_inner (
      .clock, .reset,
      .in_valid (d1_v), .in_num(d1_r), .in_den(inner_ff),
      .in_side  ({d1_side, d1_q}),
      .out_valid(d2_v), .out_quo(d2_q), .out_rem(d2_r), .out_side(d2_side)
   );

   logic                d2_op;
   logic [IdxWidth-1:0] d2_val;
   logic [PosWidth-1:0] d2_pos;
   logic [QuoWidth-1:0] d2_blk;
   assign {d2_op, d2_val, d2_pos, d2_blk} = d2_side;

   // table writes land here, in order with the reads below
   always_ff @(posedge clock) begin
      if (d2_v && d2_op == OP_WRITE && 32'(d2_pos) < TABLE_DEPTH)
         table_mem[d2_pos[AW-1:0]] <= d2_val;
   end

   // ---------------- stage A: table read
   logic                a_v_ff, a_oob_ff;
   logic [PosWidth-1:0] a_pos_ff, a_off_ff;
   logic [QuoWidth-1:0] a_blk_ff;
   logic [IdxWidth-1:0] a_raw_ff;

   always_ff @(posedge clock) begin
      a_v_ff   <= reset ? 1'b0 : (d2_v && d2_op == OP_RESOLVE);
      a_oob_ff <= 32'(d2_q) >= TABLE_DEPTH;
      a_pos_ff <= d2_pos;
      a_blk_ff <= d2_blk;
      a_off_ff <= d2_r;
      a_raw_ff <= table_mem[d2_q[AW-1:0]];
   end

   // ---------------- stage B: narrow, wrap, bound check
   logic signed [IdxWidth-1:0] b_idx;
   logic signed [IdxWidth:0]   b_fix;
   logic                       b_bad;
   assign b_idx = narrow_ff ? {{32{a_raw_ff[31]}}, a_raw_ff[31:0]} : a_raw_ff;
   assign b_fix = b_idx[IdxWidth-1] ? ({b_idx[IdxWidth-1], b_idx} + (IdxWidth+1)'(axis_ff))
                                    : {1'b0, b_idx};
   assign b_bad = b_fix[IdxWidth] || (b_fix >= (IdxWidth+1)'(axis_ff));

   logic                b_v_ff;
   logic [1:0]          b_st_ff;
   logic [PosWidth-1:0] b_pos_ff, b_off_ff;
   logic [QuoWidth-1:0] b_blk_ff;
   logic [30:0]         b_idx_ff;   // in range means below axis, so 31 bits

   always_ff @(posedge clock) begin
      b_v_ff   <= reset ? 1'b0 : a_v_ff;
      b_st_ff  <= a_oob_ff ? ST_SLOT : (b_bad ? ST_RANGE : ST_OK);
      b_pos_ff <= a_pos_ff;
      b_off_ff <= a_off_ff;
      b_blk_ff <= a_blk_ff;
      b_idx_ff <= b_fix[30:0];
   end

   // ---------------- stage C: products, split into pieces no wider than 32x32
   logic [30:0]         d2n;
   logic                c_v_ff;
   logic [1:0]          c_st_ff;
   logic [PosWidth-1:0] c_pos_ff, c_off_ff;
   logic [61:0]         c_ix_ff;
   logic [62:0]         c_lo_ff;  // block * ibs[31:0]
   logic [38:0]         c_hi_ff;  // block * ibs[39:32]

   assign d2n = (inner_ff == '0) ? 31'd1 : inner_ff;

   always_ff @(posedge clock) begin
      c_v_ff   <= reset ? 1'b0 : b_v_ff;
      c_st_ff  <= b_st_ff;
      c_pos_ff <= b_pos_ff;
      c_off_ff <= b_off_ff;
      c_ix_ff  <= 62'(b_idx_ff) * 62'(d2n);
      c_lo_ff  <= 63'(b_blk_ff) * 63'(ibs_ff[31:0]);
      c_hi_ff  <= 39'(b_blk_ff) * 39'(ibs_ff[39:32]);
   end

   // ---------------- stage D: final sum modulo 2^63
   logic [SrcWidth-1:0] d_sum;
   assign d_sum = c_lo_ff + {c_hi_ff[30:0], 32'd0} + 63'(c_ix_ff) + 63'(c_off_ff);

   always_ff @(posedge clock) begin
      rsp_valid        <= reset ? 1'b0 : c_v_ff;
      rsp_out_position <= c_pos_ff;
      rsp_status       <= c_st_ff;
      rsp_source_index <= (c_st_ff == ST_OK) ? d_sum : '0;
   end

   // ---------------- checks
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE || rsp_status == ST_SLOT))
      else $error("illegal status");
   a_zero_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_source_index == '0)
      else $error("nonzero index on error status");
   a_tail_flow: assert property (@(posedge clock) disable iff (reset)
      a_v_ff |=> b_v_ff ##1 c_v_ff ##1 rsp_valid)
      else $error("result lost in tail");
endmodule
`default_nettype wire

@@ sim/tb_gather_source_address_generator.sv @@
// Self-checking testbench for gather_source_address_generator: table writes and
// resolves with random gaps, APB register phases, checked against a local predictor.
// Depends on gsag_pkg and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_gather_source_address_generator;
   import gsag_pkg::*;

   localparam int Depth = 1024;
   localparam int DepthBits = $clog2(Depth);
   localparam int Drain = 80;          // pipeline is 2*31+4 deep; round up
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [PosWidth-1:0] pos;
      logic [SrcWidth-1:0] src;
      logic [1:0]          st;
   } gather_result_type;

   // Predictor and store of expected source addresses.
   class gather_board_type;
      longint unsigned blk_elems;
      longint unsigned axis_len;
      longint unsigned outer_div;
      longint unsigned inner_div;
      bit              narrow;
      logic [63:0]     entries [Depth];
      bit              loaded  [Depth];
      gather_result_type awaited [$];
      int              n_write, n_resolve;
      int              n_status [3];

      function new();
         blk_elems  = 0;
         axis_len   = 1;
         outer_div  = 1;
         inner_div  = 1;
         narrow     = 1;
         n_write = 0;
         n_resolve = 0;
         foreach (n_status[i]) n_status[i] = 0;
         foreach (loaded[i]) loaded[i] = 0;
      endfunction

      function void set_reg(logic [2:0] which, longint unsigned value);
         case (which)
            REG_IBS:    blk_elems  = value & 64'hFF_FFFF_FFFF;
            REG_AXIS:   axis_len   = value & 64'h7FFF_FFFF;
            REG_OUTER:  outer_div  = value & 64'h7FFF_FFFF;
            REG_INNER:  inner_div  = value & 64'h7FFF_FFFF;
            REG_NARROW: narrow     = value[0];
            default: ;
         endcase
      endfunction

      function longint unsigned slot_of(logic [PosWidth-1:0] pos);
         longint unsigned d1, d2;
         d1 = (outer_div == 0) ? 1 : outer_div;
         d2 = (inner_div == 0) ? 1 : inner_div;
         return (longint'(pos) % d1) / d2;
      endfunction

      function void note_transfer(logic op, logic [PosWidth-1:0] pos, logic [63:0] value);
         longint unsigned d1, d2, blk, rem, slot, off, sum;
         longint          idx;
         gather_result_type r;
         if (op == OP_WRITE) begin
            n_write++;
            if (pos < Depth) begin
               entries[pos[DepthBits-1:0]] = value;
               loaded[pos[DepthBits-1:0]]  = 1;
            end
            return;
         end
         n_resolve++;
         d1   = (outer_div == 0) ? 1 : outer_div;
         d2   = (inner_div == 0) ? 1 : inner_div;
         blk  = longint'(pos) / d1;
         rem  = longint'(pos) % d1;
         slot = rem / d2;
         off  = rem % d2;
         r.pos = pos;
         r.src = '0;
         if (slot >= Depth) begin
            r.st = ST_SLOT;
         end else begin
            if (narrow) idx = $signed(entries[slot[DepthBits-1:0]][31:0]);
            else        idx = $signed(entries[slot[DepthBits-1:0]]);
            if (idx < 0) idx += longint'(axis_len);
            if (idx < 0 || idx >= longint'(axis_len)) begin
               r.st = ST_RANGE;
            end else begin
               sum   = blk * blk_elems + longint'(idx) * d2 + off;
               r.src = sum[SrcWidth-1:0];
               r.st  = ST_OK;
            end
         end
         n_status[r.st]++;
         awaited.push_back(r);
      endfunction

      // Empty string when the result matches the oldest expectation.
      function string check(logic [PosWidth-1:0] pos, logic [SrcWidth-1:0] src,
                            logic [1:0] st);
         gather_result_type e;
         string msg;
         if (awaited.size() == 0)
            return $sformatf("unexpected result pos=%0d", pos);
         e = awaited.pop_front();
         msg = "";
         if (pos !== e.pos)
            msg = {msg, $sformatf(" out_position %0d exp %0d", pos, e.pos)};
         if (src !== e.src)
            msg = {msg, $sformatf(" source_index %0h exp %0h", src, e.src)};
         if (st !== e.st)
            msg = {msg, $sformatf(" status %0d exp %0d", st, e.st)};
         if (msg != "") msg = {$sformatf("pos %0d:", e.pos), msg};
         return msg;
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock, reset;
   logic start, busy;
   logic req_opcode;
   logic [PosWidth-1:0] req_position;
   logic signed [IdxWidth-1:0] req_index_value;
   logic rsp_valid;
   logic [PosWidth-1:0] rsp_out_position;
   logic [SrcWidth-1:0] rsp_source_index;
   logic [1:0] rsp_status;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [5:0] csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   gather_source_address_generator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_position(req_position),
      .req_index_value(req_index_value),
      .rsp_valid(rsp_valid), .rsp_out_position(rsp_out_position),
      .rsp_source_index(rsp_source_index), .rsp_status(rsp_status),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   gather_board_type board;
   int errors = 0;
   int cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
   endtask

   // Every result strobe is one transfer; the receiver cannot stall.
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid) begin
         msg = board.check(rsp_out_position, rsp_source_index, rsp_status);
         if (msg != "") report(msg);
      end
   end

   // Watchdog: slowest run is far below this.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // One request transfer. start is only lowered during a gap, so back-to-back
   // items never see a low/high pair of assignments in the same step.
   task automatic send(logic op, logic [PosWidth-1:0] pos, logic [63:0] value);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= op;
      req_position    <= pos;
      req_index_value <= value;
      do @(posedge clock); while (busy);
      board.note_transfer(op, pos, value);
   endtask

   // Hold the request side until all results are back, then let writes settle.
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (Drain) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] which, logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      board.set_reg(which, value);
   endtask

   task automatic load_setting(logic [63:0] ibs, logic [63:0] axis, logic [63:0] outer,
                               logic [63:0] inner, logic [63:0] nar);
      quiesce();
      csr_write(REG_IBS, ibs);
      csr_write(REG_AXIS, axis);
      csr_write(REG_OUTER, outer);
      csr_write(REG_INNER, inner);
      csr_write(REG_NARROW, nar);
   endtask

   // Index values: wide random, in range, negative in range, or near the bounds.
   function automatic logic [63:0] pick_index();
      longint a;
      a = longint'(board.axis_len);
      case ($urandom_range(0, 4))
         0: return {$urandom, $urandom};
         1: return (a > 0) ? longint'($urandom_range(0, a - 1)) : 64'd0;
         2: return (a > 0) ? -longint'($urandom_range(1, a)) : -64'sd1;
         3: return {$urandom, 32'(a)};
         default: begin
            case ($urandom_range(0, 3))
               0: return a;
               1: return -a - 1;
               2: return {$urandom, 32'h8000_0000};
               default: return {1'b1, 63'd0};
            endcase
         end
      endcase
   endfunction

   // Random table loads, and resolve positions that mostly land on table rows;
   // the slot is loaded first when it has never been written.
   task automatic random_items(int count);
      longint unsigned d1, d2, rem_top, slot, p;
      logic [PosWidth-1:0] pos;
      repeat (count) begin
         d1 = (board.outer_div == 0) ? 1 : board.outer_div;
         d2 = (board.inner_div == 0) ? 1 : board.inner_div;
         if ($urandom_range(0, 4) == 0) begin
            // table load, sometimes aimed past the depth
            p = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, Depth - 1);
            send(OP_WRITE, p[PosWidth-1:0], pick_index());
         end else begin
            if ($urandom_range(0, 3) == 0) begin
               p = $urandom;
            end else begin
               rem_top = d1 - 1;
               if (rem_top > 1100 * d2) rem_top = 1100 * d2;
               p = longint'($urandom_range(0, 2000)) * d1 + $urandom_range(0, rem_top);
            end
            pos  = p[PosWidth-1:0];
            slot = board.slot_of(pos);
            if (slot < Depth && !board.loaded[slot[DepthBits-1:0]])
               send(OP_WRITE, slot[PosWidth-1:0], pick_index());
            send(OP_RESOLVE, pos, {$urandom, $urandom});
         end
      end
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_WRITE;
      req_position = '0;
      req_index_value = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset values put every position on slot 0 with axis 1.
      send(OP_WRITE, 31'd0, 64'd0);
      send(OP_RESOLVE, 31'd0, 64'd0);
      send(OP_RESOLVE, 31'h7FFF_FFFF, '1);
      send(OP_WRITE, 31'd0, '1);                      // narrow -1 wraps to 0
      send(OP_RESOLVE, 31'd5, 64'd0);
      send(OP_WRITE, 31'd0, 64'h0000_0001_FFFF_FFFF);  // high half ignored
      send(OP_RESOLVE, 31'd6, 64'd0);
      send(OP_WRITE, 31'd0, 64'd1);                   // index == axis: zero fill
      send(OP_RESOLVE, 31'd7, 64'd0);
      send(OP_WRITE, 31'd0, 64'h8000_0000_0000_0000);
      send(OP_RESOLVE, 31'd8, 64'd0);
      send(OP_WRITE, 31'd0, 64'h0000_0000_8000_0000); // most negative 32-bit
      send(OP_RESOLVE, 31'd9, 64'd0);
      send(OP_WRITE, PosWidth'(Depth - 1), 64'h7FFF_FFFF_FFFF_FFFF);
      send(OP_WRITE, PosWidth'(Depth), 64'd3);        // past depth: dropped
      send(OP_WRITE, 31'h7FFF_FFFF, '1);              // past depth: dropped
      send(OP_WRITE, 31'd1, -64'sd2);
      send(OP_RESOLVE, 31'd10, 64'd0);
      random_items(150);

      // Register phases, extremes included; each one drains the pipe first.
      load_setting(64'hFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'd1, 64'd0);
      random_items(240);
      load_setting(64'd1000, 64'd100, 64'd64, 64'd4, 64'd1);
      random_items(240);
      load_setting(64'd0, 64'd0, 64'd0, 64'd0, 64'd1);        // zero axis, zero divisors
      random_items(120);
      load_setting({$urandom, $urandom}, 64'd50, 64'd4096, 64'd2, 64'd0);
      random_items(240);
      load_setting(64'd12345, 64'd7, 64'd3000, 64'd3, 64'd1);
      random_items(240);
      load_setting(64'hFF_FFFF_FFFF, 64'd1000, 64'd1, 64'd1, 64'd0);  // address wraps
      random_items(200);
      load_setting(64'hFF_FFFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'd0);
      random_items(120);

      quiesce();
      if (board.pending() != 0) report("expectations left over");
      $display("covered %0d table loads and %0d resolves over 8 register settings",
               board.n_write, board.n_resolve);
      $display("status mix: ok %0d, zero fill %0d, slot past depth %0d",
               board.n_status[ST_OK], board.n_status[ST_RANGE], board.n_status[ST_SLOT]);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
